### rtl/core/i2c_slave_command_buffer_core_assert.svh
// Assertion macros used by the checker file.
`ifndef I2C_SLAVE_COMMAND_BUFFER_CORE_ASSERT_SVH
`define I2C_SLAVE_COMMAND_BUFFER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define ISB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ISB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/isb_pkg.sv
package isb_pkg;

    localparam int BYTE_W = 8;
    localparam int IDX_W  = 9;

    // Queue depths
    localparam int CMD_DEPTH = 2;
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
    localparam int OUT_DEPTH = 3;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Command queue occupancy at which the input stalls
    localparam logic [CMD_CNT_W-1:0] CMD_FULL_CNT = CMD_CNT_W'(CMD_DEPTH);

    // Request kinds
    typedef enum logic [1:0] {
        REQ_BUS     = 2'd0,
        REQ_HOST_WR = 2'd1,
        REQ_HOST_RD = 2'd2,
        REQ_DONE    = 2'd3
    } t_req;

    // Two-wire controller status codes (low three bits masked off)
    localparam logic [7:0] STAT_MASK   = 8'hF8;
    localparam logic [7:0] ST_SR_ADDR  = 8'hA8;
    localparam logic [7:0] ST_SR_ARB   = 8'hB0;
    localparam logic [7:0] ST_TX_ACK   = 8'hB8;
    localparam logic [7:0] ST_TX_NACK  = 8'hC0;
    localparam logic [7:0] ST_SW_ADDR  = 8'h60;
    localparam logic [7:0] ST_SW_ARB   = 8'h68;
    localparam logic [7:0] ST_RX_DATA  = 8'h80;

    // Command code stored when a new write frame opens
    localparam logic [7:0] CODE_NONE = 8'hFF;

    // Classified operations
    typedef enum logic [3:0] {
        OP_RD_ADDR   = 4'd0,
        OP_TX_ACK    = 4'd1,
        OP_TX_NACK   = 4'd2,
        OP_WR_ADDR   = 4'd3,
        OP_RX_DATA   = 4'd4,
        OP_BUS_OTHER = 4'd5,
        OP_HOST_WR   = 4'd6,
        OP_HOST_RD   = 4'd7,
        OP_DONE      = 4'd8
    } t_op;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [7:0]        bus_status;
        logic [7:0]        bus_byte;
        logic [IDX_W-1:0]  host_index;
        logic [7:0]        host_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_loaded;
        logic       ack_enable;
        logic       order_pending;
        logic [7:0] host_read_byte;
    } t_out_word;

    // Classified command handed from front to back
    typedef struct packed {
        t_op               op;
        logic [7:0]        data;
        logic [IDX_W-1:0]  index;
    } t_cmd;

endpackage

### rtl/core/isb_fifo.sv
module isb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [WIDTH-1:0]               i_data,
    input  logic                           i_pop,
    output logic                           o_valid,
    output logic [WIDTH-1:0]               o_data,
    output logic [$clog2(DEPTH+1)-1:0]     o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             full;
    logic             do_push, do_pop;

    assign o_valid = (r_count != '0);
    assign full    = (r_count == CNT_W'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    assign do_push = i_push && !full;
    assign do_pop  = i_pop && o_valid;

    // Pointer wrap and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/core/isb_front.sv
module isb_front (
    input  logic              i_in_valid,
    input  isb_pkg::t_in_word i_in_word,
    input  logic              i_q_full,
    output logic              o_in_stall,
    output logic              o_push,
    output isb_pkg::t_cmd     o_cmd
);

    logic [7:0] status;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;
    assign status     = i_in_word.bus_status & isb_pkg::STAT_MASK;

    // Classify the request into one operation
    always_comb begin
        o_cmd.index = i_in_word.host_index;
        o_cmd.data  = i_in_word.bus_byte;
        o_cmd.op    = isb_pkg::OP_BUS_OTHER;
        unique case (isb_pkg::t_req'(i_in_word.req_type))
            isb_pkg::REQ_BUS: begin
                unique case (status)
                    isb_pkg::ST_SR_ADDR,
                    isb_pkg::ST_SR_ARB:  o_cmd.op = isb_pkg::OP_RD_ADDR;
                    isb_pkg::ST_TX_ACK:  o_cmd.op = isb_pkg::OP_TX_ACK;
                    isb_pkg::ST_TX_NACK: o_cmd.op = isb_pkg::OP_TX_NACK;
                    isb_pkg::ST_SW_ADDR,
                    isb_pkg::ST_SW_ARB:  o_cmd.op = isb_pkg::OP_WR_ADDR;
                    isb_pkg::ST_RX_DATA: o_cmd.op = isb_pkg::OP_RX_DATA;
                    default:             o_cmd.op = isb_pkg::OP_BUS_OTHER;
                endcase
            end
            isb_pkg::REQ_HOST_WR: begin
                o_cmd.op   = isb_pkg::OP_HOST_WR;
                o_cmd.data = i_in_word.host_byte;
            end
            isb_pkg::REQ_HOST_RD: o_cmd.op = isb_pkg::OP_HOST_RD;
            isb_pkg::REQ_DONE:    o_cmd.op = isb_pkg::OP_DONE;
        endcase
    end

endmodule

### rtl/core/isb_back.sv
module isb_back #(
    parameter int DATA_BYTES = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    input  isb_pkg::t_cmd                   i_cmd,
    output logic                            o_cmd_pop,
    input  logic [isb_pkg::OUT_CNT_W-1:0]   i_out_count,
    output logic                            o_res_valid,
    output isb_pkg::t_out_word              o_res
);

    localparam int MBOX_DEPTH = DATA_BYTES + 2;
    localparam int POS_W      = $clog2(MBOX_DEPTH);
    localparam int MEM_AW     = $clog2(DATA_BYTES);
    localparam int CMP_W      = (POS_W + 1 > isb_pkg::IDX_W + 1) ? POS_W + 1
                                                                  : isb_pkg::IDX_W + 1;
    localparam int OCC_W      = isb_pkg::OUT_CNT_W + 1;

    // Frame state
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_in_rx, n_in_rx;
    logic             r_pend, n_pend;
    logic             r_ack, n_ack;
    logic [7:0]       r_code, n_code;
    logic [7:0]       r_len, n_len;

    // Data byte storage
    logic [7:0]        r_mem [DATA_BYTES];
    logic [7:0]        r_mem_q;
    logic              mem_we, mem_re;
    logic [MEM_AW-1:0] mem_wa, mem_ra;

    // Result stage
    logic       r_rd_vld;
    logic       r_rd_loaded, n_rd_loaded;
    logic       r_rd_hread, n_rd_hread;
    logic       r_rd_src_mem, n_rd_src_mem;
    logic [7:0] r_rd_byte, n_rd_byte;
    logic       r_rd_ack, r_rd_pend;
    logic [7:0] rd_val;

    logic [CMP_W-1:0]  pos_x, pos_inc, idx_x, len_end;
    logic [7:0]        len_eff;
    logic              end_hit, idx_ok;
    logic [MEM_AW-1:0] pos_mem, idx_mem;

    // Issue only when the output queue is sure to have room
    assign o_cmd_pop = i_cmd_valid &&
                       ((OCC_W'(i_out_count) + OCC_W'(r_rd_vld)) < OCC_W'(isb_pkg::OUT_DEPTH));

    // Position arithmetic and end-of-frame test
    always_comb begin
        pos_x   = CMP_W'(r_pos);
        pos_inc = pos_x + CMP_W'(1);
        idx_x   = CMP_W'(i_cmd.index);
        idx_ok  = idx_x < CMP_W'(MBOX_DEPTH);
        len_eff = (i_cmd.op == isb_pkg::OP_RX_DATA && r_pos == POS_W'(1)) ? i_cmd.data
                                                                            : r_len;
        len_end = CMP_W'(len_eff) + CMP_W'(2);
        end_hit = (pos_inc >= CMP_W'(MBOX_DEPTH)) ||
                  ((pos_inc >= CMP_W'(2)) && (pos_inc >= len_end));
        pos_mem = MEM_AW'(pos_x - CMP_W'(2));
        idx_mem = MEM_AW'(idx_x - CMP_W'(2));
    end

    // Execute one command
    always_comb begin
        n_pos        = r_pos;
        n_in_rx      = r_in_rx;
        n_pend       = r_pend;
        n_ack        = r_ack;
        n_code       = r_code;
        n_len        = r_len;
        mem_we       = 1'b0;
        mem_wa       = idx_mem;
        mem_re       = 1'b0;
        mem_ra       = idx_mem;
        n_rd_loaded  = 1'b0;
        n_rd_hread   = 1'b0;
        n_rd_src_mem = 1'b0;
        n_rd_byte    = '0;
        if (o_cmd_pop) begin
            unique case (i_cmd.op)
                isb_pkg::OP_RD_ADDR: begin
                    n_rd_loaded = 1'b1;
                    n_rd_byte   = r_code;
                    n_pos       = POS_W'(1);
                    n_ack       = 1'b1;
                end
                isb_pkg::OP_TX_ACK: begin
                    n_rd_loaded = 1'b1;
                    if (r_pos == POS_W'(0)) begin
                        n_rd_byte = r_code;
                    end else if (r_pos == POS_W'(1)) begin
                        n_rd_byte = r_len;
                    end else begin
                        n_rd_src_mem = 1'b1;
                        mem_re       = 1'b1;
                        mem_ra       = pos_mem;
                    end
                    n_pos = end_hit ? '0 : POS_W'(pos_inc);
                    n_ack = 1'b1;
                end
                isb_pkg::OP_TX_NACK: begin
                    n_pos = '0;
                    n_ack = 1'b1;
                end
                isb_pkg::OP_WR_ADDR: begin
                    n_in_rx = 1'b1;
                    n_code  = isb_pkg::CODE_NONE;
                    n_len   = '0;
                    n_pos   = '0;
                    n_ack   = 1'b1;
                end
                isb_pkg::OP_RX_DATA: begin
                    if (r_pos == POS_W'(0)) begin
                        n_code = i_cmd.data;
                    end else if (r_pos == POS_W'(1)) begin
                        n_len = i_cmd.data;
                    end else begin
                        mem_we = 1'b1;
                        mem_wa = pos_mem;
                    end
                    if (end_hit) begin
                        n_ack   = 1'b0;
                        n_in_rx = 1'b0;
                        n_pend  = 1'b1;
                        n_pos   = '0;
                    end else begin
                        n_pos = POS_W'(pos_inc);
                        n_ack = 1'b1;
                    end
                end
                isb_pkg::OP_BUS_OTHER: begin
                    if (r_pend) begin
                        n_ack = 1'b0;
                    end else if (r_in_rx) begin
                        n_ack   = 1'b0;
                        n_in_rx = 1'b0;
                        n_pend  = 1'b1;
                        n_pos   = '0;
                    end else begin
                        n_pos   = '0;
                        n_in_rx = 1'b0;
                        n_ack   = 1'b1;
                    end
                end
                isb_pkg::OP_HOST_WR: begin
                    if (idx_ok) begin
                        if (idx_x == CMP_W'(0)) begin
                            n_code = i_cmd.data;
                        end else if (idx_x == CMP_W'(1)) begin
                            n_len = i_cmd.data;
                        end else begin
                            mem_we = 1'b1;
                        end
                    end
                end
                isb_pkg::OP_HOST_RD: begin
                    if (idx_ok) begin
                        n_rd_hread = 1'b1;
                        if (idx_x == CMP_W'(0)) begin
                            n_rd_byte = r_code;
                        end else if (idx_x == CMP_W'(1)) begin
                            n_rd_byte = r_len;
                        end else begin
                            n_rd_src_mem = 1'b1;
                            mem_re       = 1'b1;
                        end
                    end
                end
                isb_pkg::OP_DONE: begin
                    if (r_pend) begin
                        n_pend = 1'b0;
                        n_ack  = 1'b1;
                    end
                end
                default: begin
                    n_pos = r_pos;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_in_rx  <= 1'b0;
            r_pend   <= 1'b0;
            r_ack    <= 1'b1;
            r_rd_vld <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_in_rx  <= n_in_rx;
            r_pend   <= n_pend;
            r_ack    <= n_ack;
            r_rd_vld <= o_cmd_pop;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_code       <= n_code;
        r_len        <= n_len;
        r_rd_loaded  <= n_rd_loaded;
        r_rd_hread   <= n_rd_hread;
        r_rd_src_mem <= n_rd_src_mem;
        r_rd_byte    <= n_rd_byte;
        r_rd_ack     <= n_ack;
        r_rd_pend    <= n_pend;
    end

    // Data memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= i_cmd.data;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_ra];
        end
    end

    // Assemble the result word
    assign rd_val      = r_rd_src_mem ? r_mem_q : r_rd_byte;
    assign o_res_valid = r_rd_vld;
    always_comb begin
        o_res.tx_byte        = r_rd_loaded ? rd_val : '0;
        o_res.tx_loaded      = r_rd_loaded;
        o_res.ack_enable     = r_rd_ack;
        o_res.order_pending  = r_rd_pend;
        o_res.host_read_byte = r_rd_hread ? rd_val : '0;
    end

endmodule

### rtl/core/i2c_slave_command_buffer_core.sv
// I2C slave command mailbox framer.
// Input channel (i_in_valid / o_in_stall / i_in_word) carries one word per
// controller status event or host request: bus event, host buffer write,
// host buffer read or host order done. Every input word yields exactly one
// output word on (o_out_valid / i_out_stall / o_out_word), in order.
// A front decoder classifies each word into a two-entry command queue; the
// back end updates the frame state and the data byte memory and registers
// the result into a three-entry output queue.
// Path: an accepted word passes through the command queue, the back end
// result registers and the output queue before it is offered on the output.
// Throughput: one word per cycle while the receiver does not stall, set by the
// back end issuing one command a cycle, memory read registered in result stage.
// Reset: frame position and receive flag clear, order pending clears and
// acknowledge is enabled; both queues empty. Mailbox contents are undefined
// until written.
// When the receiver stalls, the output queue fills, the back end holds off,
// the command queue fills and o_in_stall rises; no word is lost.
module i2c_slave_command_buffer_core #(
    parameter int DATA_BYTES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  isb_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output isb_pkg::t_out_word o_out_word
);

    localparam int CMD_W = $bits(isb_pkg::t_cmd);
    localparam int OUT_W = $bits(isb_pkg::t_out_word);

    logic                          cmd_push, cmd_full, cmd_valid, cmd_pop;
    isb_pkg::t_cmd                 cmd_in, cmd_out;
    logic [CMD_W-1:0]              cmd_bits;
    logic [isb_pkg::CMD_CNT_W-1:0] cmd_count;
    logic                          res_valid;
    isb_pkg::t_out_word            res_word;
    logic [isb_pkg::OUT_CNT_W-1:0] out_count;
    logic [OUT_W-1:0]              out_bits;

    // Front: decode incoming words
    isb_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .i_q_full   (cmd_full),
        .o_in_stall (o_in_stall),
        .o_push     (cmd_push),
        .o_cmd      (cmd_in)
    );

    // Command queue between front and back
    isb_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (isb_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_data  (cmd_bits),
        .o_count (cmd_count)
    );

    assign cmd_full = (cmd_count == isb_pkg::CMD_FULL_CNT);
    assign cmd_out  = isb_pkg::t_cmd'(cmd_bits);

    // Back: frame state, mailbox and results
    isb_back #(
        .DATA_BYTES (DATA_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_out_count (out_count),
        .o_res_valid (res_valid),
        .o_res       (res_word)
    );

    // Output queue decouples the receiver
    isb_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (isb_pkg::OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res_word),
        .i_pop   (!i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (out_bits),
        .o_count (out_count)
    );

    assign o_out_word = isb_pkg::t_out_word'(out_bits);

endmodule

### rtl/core/isb_checker.sv
`include "i2c_slave_command_buffer_core_assert.svh"

module isb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input isb_pkg::t_in_word  i_in_word,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input isb_pkg::t_out_word o_out_word
);

    // A stalled input word holds
    `ISB_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall, i_in_valid && $stable(i_in_word), "input word changed while stalled")

    // A stalled output word holds
    `ISB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word), "output word changed while stalled")

    // Acknowledge goes off only together with a pending order
    `ISB_ASSERT_NOW(a_nack_pending, i_clk, i_rst_n, o_out_valid && !o_out_word.ack_enable, o_out_word.order_pending, "nack without pending order")

    // No transmit byte unless one was loaded
    `ISB_ASSERT_NOW(a_tx_zero, i_clk, i_rst_n, o_out_valid && !o_out_word.tx_loaded, o_out_word.tx_byte == 8'h00, "tx byte set without load")

    // Transmit load and host read never share a word
    `ISB_ASSERT_NOW(a_tx_vs_host, i_clk, i_rst_n, o_out_valid && o_out_word.tx_loaded, o_out_word.host_read_byte == 8'h00, "host read byte on transmit word")

endmodule

bind i2c_slave_command_buffer_core isb_checker u_isb_checker (.*);
